### rtl/core/iss_pkg.sv
// iss_pkg: shared types, constants and scaling tables for the imu sample scaler
// no dependencies; imported by iss_lane and imu_sample_scaler
package iss_pkg;

    localparam int RAW_W       = 16;
    localparam int MAG_W       = 16;
    localparam int VAL_W       = 25;
    localparam int NUM_W       = 20;
    localparam int HALF_W      = 15;
    localparam int PROD_W      = 35;
    localparam int NUM32_W     = 32;
    localparam int QUO_W       = 25;
    localparam int DIV_W       = 16;
    localparam int RECIP_W     = 25;
    localparam int RPROD_W     = NUM32_W + RECIP_W;
    localparam int STAT_W      = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int SHIFT_W     = 4;

    localparam logic [SHIFT_W-1:0] ACCEL_SHIFT_BASE = SHIFT_W'(14);
    localparam logic [VAL_W-1:0]   TEMP_OFFSET      = VAL_W'(294150);

    localparam logic [1:0] DEV_DISCONNECTED = 2'd0;
    localparam logic [1:0] DEV_ASLEEP       = 2'd1;

    typedef enum logic [1:0] {
        FUNC_ACCEL = 2'd0,
        FUNC_GYRO  = 2'd1,
        FUNC_MAG   = 2'd2,
        FUNC_TEMP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_NOT_CONNECTED = 2'd1,
        STATUS_NOT_PERMITTED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_DEVICE_STATE = 3'd0,
        CFG_ACCEL_RANGE  = 3'd1,
        CFG_GYRO_RANGE   = 3'd2,
        CFG_MAG_ENABLED  = 3'd3,
        CFG_TEMP_ENABLED = 3'd4
    } cfg_idx_t;

    // stage load strobes shared by every lane
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } load_t;

    function automatic logic [NUM_W-1:0] scale_num(func_t f, logic [1:0] sel);
        logic [NUM_W-1:0] r;
        case (f)
            FUNC_ACCEL: r = NUM_W'(1000000);
            FUNC_GYRO:  r = (sel == 2'd0) ? NUM_W'(1000) : NUM_W'(10000);
            FUNC_MAG:   r = NUM_W'(150);
            FUNC_TEMP:  r = NUM_W'(100000);
            default:    r = '0;
        endcase
        return r;
    endfunction

    // half the divisor, rounded down; added to the scaled magnitude before truncation
    function automatic logic [HALF_W-1:0] round_half(func_t f, logic [1:0] sel);
        logic [HALF_W-1:0] r;
        case (f)
            FUNC_ACCEL:
            begin
                case (sel)
                    2'd0:    r = HALF_W'(8192);
                    2'd1:    r = HALF_W'(4096);
                    2'd2:    r = HALF_W'(2048);
                    default: r = HALF_W'(1024);
                endcase
            end
            FUNC_GYRO:
            begin
                case (sel)
                    2'd0:    r = HALF_W'(65);
                    2'd1:    r = HALF_W'(327);
                    2'd2:    r = HALF_W'(164);
                    default: r = HALF_W'(82);
                endcase
            end
            FUNC_TEMP: r = HALF_W'(16693);
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] divisor(func_t f, logic [1:0] sel);
        logic [DIV_W-1:0] r;
        case (f)
            FUNC_GYRO:
            begin
                case (sel)
                    2'd0:    r = DIV_W'(131);
                    2'd1:    r = DIV_W'(655);
                    2'd2:    r = DIV_W'(328);
                    default: r = DIV_W'(164);
                endcase
            end
            FUNC_TEMP: r = DIV_W'(33387);
            default:   r = DIV_W'(1);
        endcase
        return r;
    endfunction

    // floor(2^32 / divisor); estimate is the quotient or one below it
    function automatic logic [RECIP_W-1:0] recip(func_t f, logic [1:0] sel);
        logic [RECIP_W-1:0] r;
        case (f)
            FUNC_GYRO:
            begin
                case (sel)
                    2'd0:    r = RECIP_W'(32786009);
                    2'd1:    r = RECIP_W'(6557201);
                    2'd2:    r = RECIP_W'(13094412);
                    default: r = RECIP_W'(26188824);
                endcase
            end
            FUNC_TEMP: r = RECIP_W'(128641);
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/iss_lane.sv
// iss_lane: one axis of the scaler, multiply, round and constant divide in three stages
// depends on iss_pkg
module iss_lane (
    input  logic                            clk,
    input  iss_pkg::load_t                  load,
    input  iss_pkg::func_t                  func,
    input  logic [1:0]                      sel,
    input  logic signed [iss_pkg::RAW_W-1:0] raw,
    output logic signed [iss_pkg::VAL_W-1:0] value
);
    import iss_pkg::*;

    // stage 1: magnitude times scale plus rounding half
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] n1_next;
    logic [PROD_W-1:0] n1_reg;
    func_t             f1_reg;
    logic [1:0]        sel1_reg;
    logic              neg1_reg;

    // stage 2: quotient estimate
    logic [SHIFT_W-1:0] acc_shift;
    logic [RPROD_W-1:0] rprod;
    logic [QUO_W-1:0]   q2_next;
    logic [QUO_W-1:0]   q2_reg;
    logic [NUM32_W-1:0] n2_reg;
    logic [DIV_W-1:0]   d2_reg;
    logic               exact2_reg;
    logic               neg2_reg;
    logic               temp2_reg;

    // stage 3: back-multiply for the correction
    logic [QUO_W+DIV_W-1:0] back_next;
    logic [NUM32_W-1:0]     back3_reg;
    logic [QUO_W-1:0]       q3_reg;
    logic [NUM32_W-1:0]     n3_reg;
    logic [DIV_W-1:0]       d3_reg;
    logic                   exact3_reg;
    logic                   neg3_reg;
    logic                   temp3_reg;

    logic [NUM32_W-1:0] rem;
    logic               bump;
    logic [QUO_W-1:0]   qf;
    logic [VAL_W-1:0]   sval;

    assign mag     = raw[RAW_W-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
    assign n1_next = PROD_W'(mag) * PROD_W'(scale_num(func, sel))
                   + PROD_W'(round_half(func, sel));

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            n1_reg   <= n1_next;
            f1_reg   <= func;
            sel1_reg <= sel;
            neg1_reg <= raw[RAW_W-1];
        end
    end

    assign acc_shift = ACCEL_SHIFT_BASE - SHIFT_W'(sel1_reg);
    assign rprod     = RPROD_W'(n1_reg[NUM32_W-1:0]) * RPROD_W'(recip(f1_reg, sel1_reg));

    always_comb
    begin
        case (f1_reg)
            FUNC_ACCEL: q2_next = QUO_W'(n1_reg >> acc_shift);
            FUNC_MAG:   q2_next = QUO_W'(n1_reg);
            default:    q2_next = rprod[RPROD_W-1:NUM32_W];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            q2_reg     <= q2_next;
            n2_reg     <= n1_reg[NUM32_W-1:0];
            d2_reg     <= divisor(f1_reg, sel1_reg);
            exact2_reg <= (f1_reg == FUNC_ACCEL) || (f1_reg == FUNC_MAG);
            neg2_reg   <= neg1_reg;
            temp2_reg  <= (f1_reg == FUNC_TEMP);
        end
    end

    assign back_next = (QUO_W+DIV_W)'(q2_reg) * (QUO_W+DIV_W)'(d2_reg);

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            back3_reg  <= back_next[NUM32_W-1:0];
            q3_reg     <= q2_reg;
            n3_reg     <= n2_reg;
            d3_reg     <= d2_reg;
            exact3_reg <= exact2_reg;
            neg3_reg   <= neg2_reg;
            temp3_reg  <= temp2_reg;
        end
    end

    // estimate never exceeds the true quotient, so the remainder is non-negative
    assign rem   = n3_reg - back3_reg;
    assign bump  = !exact3_reg && (rem >= NUM32_W'(d3_reg));
    assign qf    = q3_reg + QUO_W'(bump);
    assign sval  = neg3_reg ? VAL_W'(~qf + 1'b1) : VAL_W'(qf);
    assign value = temp3_reg ? signed'(sval + TEMP_OFFSET) : signed'(sval);

endmodule

### rtl/core/imu_sample_scaler.sv
// imu_sample_scaler: top level, config registers, status, three axis lanes and result merge
// depends on iss_pkg and iss_lane
//
// Converts one raw three-axis sample per beat into physical units: micro-g for the
// accelerometer, milli-degrees per second for the gyroscope, nanotesla for the
// magnetometer and milli-units for die temperature (x only). Status and the enables
// are taken from the config registers when the sample is accepted; on any error all
// three values are zero. A sample passes through the three lane stages (multiply,
// reciprocal estimate and back-multiply correction) and then the merged output register,
// and one sample is accepted every cycle while in_ready is high; each stage holds its
// item when the stage ahead of it is full and cannot take it, so bubbles are filled
// while the output waits.
module imu_sample_scaler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [iss_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [iss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic signed [iss_pkg::RAW_W-1:0]     x_raw,
    input  logic signed [iss_pkg::RAW_W-1:0]     y_raw,
    input  logic signed [iss_pkg::RAW_W-1:0]     z_raw,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [iss_pkg::STAT_W-1:0]           status,
    output logic signed [iss_pkg::VAL_W-1:0]     x_value,
    output logic signed [iss_pkg::VAL_W-1:0]     y_value,
    output logic signed [iss_pkg::VAL_W-1:0]     z_value
);
    import iss_pkg::*;

    logic [1:0] device_state_reg;
    logic [2:0] accel_range_reg;
    logic [2:0] gyro_range_reg;
    logic       mag_enabled_reg;
    logic       temp_enabled_reg;

    func_t      fn;
    logic [1:0] sel;
    status_t    status_next;
    load_t      load;
    logic       load4;

    logic    v1_reg, v2_reg, v3_reg;
    status_t st1_reg, st2_reg, st3_reg;
    logic    yz1_reg, yz2_reg, yz3_reg;

    logic                    out_valid_reg;
    status_t                 status_reg;
    logic signed [VAL_W-1:0] x_value_reg, y_value_reg, z_value_reg;
    logic signed [VAL_W-1:0] x_lane, y_lane, z_lane;
    logic signed [VAL_W-1:0] x_value_next, y_value_next, z_value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_state_reg <= '0;
            accel_range_reg  <= '0;
            gyro_range_reg   <= '0;
            mag_enabled_reg  <= 1'b0;
            temp_enabled_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DEVICE_STATE: device_state_reg <= cfg_wdata[1:0];
                CFG_ACCEL_RANGE:  accel_range_reg  <= cfg_wdata;
                CFG_GYRO_RANGE:   gyro_range_reg   <= cfg_wdata;
                CFG_MAG_ENABLED:  mag_enabled_reg  <= cfg_wdata[0];
                CFG_TEMP_ENABLED: temp_enabled_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign fn = func_t'(func);

    // range codes 1..4 map to table index 0..3
    always_comb
    begin
        case (fn)
            FUNC_ACCEL: sel = accel_range_reg[1:0] - 2'd1;
            FUNC_GYRO:  sel = gyro_range_reg[1:0] - 2'd1;
            default:    sel = 2'd0;
        endcase
    end

    always_comb
    begin
        if (device_state_reg == DEV_DISCONNECTED)
            status_next = STATUS_NOT_CONNECTED;
        else if (device_state_reg == DEV_ASLEEP)
            status_next = STATUS_NOT_PERMITTED;
        else
        begin
            case (fn)
                FUNC_ACCEL: status_next = (accel_range_reg >= 3'd1 && accel_range_reg <= 3'd4)
                                          ? STATUS_OK : STATUS_NOT_PERMITTED;
                FUNC_GYRO:  status_next = (gyro_range_reg >= 3'd1 && gyro_range_reg <= 3'd4)
                                          ? STATUS_OK : STATUS_NOT_PERMITTED;
                FUNC_MAG:   status_next = mag_enabled_reg ? STATUS_OK : STATUS_NOT_PERMITTED;
                FUNC_TEMP:  status_next = temp_enabled_reg ? STATUS_OK : STATUS_NOT_PERMITTED;
                default:    status_next = STATUS_NOT_PERMITTED;
            endcase
        end
    end

    // a stage loads when it is empty or the stage ahead of it loads
    assign load4   = !out_valid_reg || out_ready;
    assign load.s3 = !v3_reg || load4;
    assign load.s2 = !v2_reg || load.s3;
    assign load.s1 = !v1_reg || load.s2;
    assign in_ready = load.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load.s1)
                v1_reg <= in_valid;
            if (load.s2)
                v2_reg <= v1_reg;
            if (load.s3)
                v3_reg <= v2_reg;
            if (load4)
                out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            st1_reg <= status_next;
            yz1_reg <= (fn == FUNC_TEMP);
        end
        if (load.s2)
        begin
            st2_reg <= st1_reg;
            yz2_reg <= yz1_reg;
        end
        if (load.s3)
        begin
            st3_reg <= st2_reg;
            yz3_reg <= yz2_reg;
        end
    end

    iss_lane u_lane_x (
        .clk   (clk),
        .load  (load),
        .func  (fn),
        .sel   (sel),
        .raw   (x_raw),
        .value (x_lane)
    );

    iss_lane u_lane_y (
        .clk   (clk),
        .load  (load),
        .func  (fn),
        .sel   (sel),
        .raw   (y_raw),
        .value (y_lane)
    );

    iss_lane u_lane_z (
        .clk   (clk),
        .load  (load),
        .func  (fn),
        .sel   (sel),
        .raw   (z_raw),
        .value (z_lane)
    );

    // merge: zero every axis on error, zero y and z for temperature
    assign x_value_next = (st3_reg != STATUS_OK) ? '0 : x_lane;
    assign y_value_next = (st3_reg != STATUS_OK || yz3_reg) ? '0 : y_lane;
    assign z_value_next = (st3_reg != STATUS_OK || yz3_reg) ? '0 : z_lane;

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            status_reg  <= st3_reg;
            x_value_reg <= x_value_next;
            y_value_reg <= y_value_next;
            z_value_reg <= z_value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = STAT_W'(status_reg);
    assign x_value   = x_value_reg;
    assign y_value   = y_value_reg;
    assign z_value   = z_value_reg;

endmodule
